>>> rtl/core/lpgp_pkg.sv
// Shared types and constants of the LED palette gradient pixel engine.
package lpgp_pkg;

    localparam int COORD_W = 8;
    localparam int PHASE_W = 11;
    localparam int PAL_N   = 6;
    localparam int PAL_W   = 24;
    localparam int PARAM_W = 16;
    localparam int MODE_W  = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int BASE_W  = 12;
    localparam int OFS_W   = 11;
    localparam int POS_W   = 13;
    localparam int DIMV_W  = 3;
    localparam int DIMD_W  = 2;

    localparam logic [PHASE_W-1:0] PHASE_SPAN = 11'd1536;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 11'd1535;

    // effect_param bit positions
    localparam int PRM_REVERSE = 0;
    localparam int PRM_INVERT  = 1;
    localparam int PRM_DIM     = 2;
    localparam int PRM_ARM_INV = 3;
    localparam int PRM_SEL_LO  = 2;

    // clock dim saturation divider codes
    localparam logic [DIMD_W-1:0] DIV_ONE   = 2'd0;
    localparam logic [DIMD_W-1:0] DIV_TWO   = 2'd1;
    localparam logic [DIMD_W-1:0] DIV_THREE = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALL,
        MODE_RADIAL,
        MODE_CLOCK,
        MODE_RMIX,
        MODE_SPIRAL,
        MODE_TREE,
        MODE_CART,
        MODE_MONO
    } t_mode;

    typedef enum logic [2:0] {
        REG_PAL0,
        REG_PAL1,
        REG_PAL2,
        REG_PAL3,
        REG_PAL4,
        REG_PAL5,
        REG_MODE,
        REG_PARAM
    } t_reg_idx;

    typedef logic [PAL_N-1:0][PAL_W-1:0] t_palette;

    typedef struct packed {
        t_palette            palette;
        t_mode               mode;
        logic [PARAM_W-1:0]  param;
        logic [DIMV_W-1:0]   dim_v;
        logic [DIMD_W-1:0]   dim_div;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0]  idx;
        logic [BASE_W-1:0]   base;
        logic [OFS_W-1:0]    ofs;
        logic                dim;
    } t_pos_item;

endpackage

>>> rtl/core/lpgp_regs.sv
// Configuration register file with APB-style access and derived clock dim terms.
module lpgp_regs import lpgp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    localparam t_palette PAL_RESET = {24'hD5FFFF, 24'hABFFFF, 24'h80FFFF,
                                      24'h55FFFF, 24'h2BFFFF, 24'h00FFFF};

    // reciprocals: exact floor division over the full operand range
    localparam logic [16:0] RECIP7  = 17'd74899;
    localparam logic [15:0] RECIP11 = 16'd47663;
    localparam logic [13:0] RECIP5  = 14'd13108;
    localparam logic [12:0] RECIP3  = 13'd5462;

    t_palette           r_palette;
    t_mode              r_mode;
    logic [PARAM_W-1:0] r_param;
    logic [13:0]        r_q7, r_q7b;
    logic [12:0]        r_q11, r_q11b;
    logic [10:0]        r_q7d5, r_q11d3;
    logic [DIMV_W-1:0]  r_dim_v;
    logic [DIMD_W-1:0]  r_dim_div;

    logic               w_wr;
    t_reg_idx           w_idx;
    logic [2:0]         w_pal_sel;
    logic [32:0]        w_p7;
    logic [31:0]        w_p11;
    logic [26:0]        w_p5;
    logic [24:0]        w_p3;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_idx     = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_pal_sel = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette <= PAL_RESET;
            r_mode    <= MODE_ALL;
            r_param   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_PAL0, REG_PAL1, REG_PAL2,
                REG_PAL3, REG_PAL4, REG_PAL5: r_palette[w_pal_sel] <= pwdata[PAL_W-1:0];
                REG_MODE:  r_mode  <= t_mode'(pwdata[MODE_W-1:0]);
                REG_PARAM: r_param <= pwdata[PARAM_W-1:0];
                default: ;
            endcase
        end
    end

    // param/7 % 5 and param/11 % 3, three register steps after a write
    assign w_p7  = 33'(r_param) * 33'(RECIP7);
    assign w_p11 = 32'(r_param) * 32'(RECIP11);
    assign w_p5  = 27'(r_q7) * 27'(RECIP5);
    assign w_p3  = 25'(r_q11) * 25'(RECIP3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q7      <= '0;
            r_q11     <= '0;
            r_q7b     <= '0;
            r_q11b    <= '0;
            r_q7d5    <= '0;
            r_q11d3   <= '0;
            r_dim_v   <= '0;
            r_dim_div <= '0;
        end else begin
            r_q7      <= w_p7[32:19];
            r_q11     <= w_p11[31:19];
            r_q7b     <= r_q7;
            r_q11b    <= r_q11;
            r_q7d5    <= w_p5[26:16];
            r_q11d3   <= w_p3[24:14];
            r_dim_v   <= DIMV_W'(r_q7b - 14'(r_q7d5) * 14'd5);
            r_dim_div <= DIMD_W'(r_q11b - 13'(r_q11d3) * 13'd3);
        end
    end

    always_comb begin
        case (w_idx)
            REG_PAL0, REG_PAL1, REG_PAL2,
            REG_PAL3, REG_PAL4, REG_PAL5: prdata = DATA_W'(r_palette[w_pal_sel]);
            REG_MODE:  prdata = DATA_W'(r_mode);
            REG_PARAM: prdata = DATA_W'(r_param);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.palette = r_palette;
    assign o_cfg.mode    = r_mode;
    assign o_cfg.param   = r_param;
    assign o_cfg.dim_v   = r_dim_v;
    assign o_cfg.dim_div = r_dim_div;

endmodule

>>> rtl/core/lpgp_pos.sv
// Stage 1: phase folding, per-mode coordinate and palette position terms.
module lpgp_pos import lpgp_pkg::*; #(
    parameter int LED_COUNT = 150
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_led_index,
    input  logic [COORD_W-1:0] i_radius,
    input  logic [COORD_W-1:0] i_angle,
    input  logic [COORD_W-1:0] i_branch,
    input  logic [COORD_W-1:0] i_pos_x,
    input  logic [COORD_W-1:0] i_pos_y,
    input  logic [PHASE_W-1:0] i_phase,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output t_pos_item          o_item
);

    localparam int IDX_DEPTH    = 2 ** COORD_W;
    localparam int RAD_W        = 19;
    localparam int RADIAL_SCALE = 1380;
    localparam int SECTOR       = 43;
    localparam int SECTOR_OFS   = 20;
    localparam logic [COORD_W-1:0] MID         = 8'd128;
    localparam logic [COORD_W-1:0] BRANCH_MAIN = 8'd30;

    localparam logic [2:0] CART_Y     = 3'd0;
    localparam logic [2:0] CART_X     = 3'd1;
    localparam logic [2:0] CART_SUM   = 3'd2;
    localparam logic [2:0] CART_DIFF  = 3'd3;
    localparam logic [2:0] CART_XYABS = 3'd4;
    localparam logic [2:0] CART_XYMIR = 3'd5;
    localparam logic [2:0] CART_YXABS = 3'd6;
    localparam logic [2:0] CART_YXMIR = 3'd7;

    logic               r_valid;
    t_pos_item          r_item;
    t_pos_item          n_item;

    logic [OFS_W-1:0]   w_ofs_fwd [IDX_DEPTH];
    logic [OFS_W-1:0]   w_ofs_inv [IDX_DEPTH];
    logic [PHASE_W-1:0] w_ph, w_p;
    logic               w_rev, w_inv, w_main, w_odd;
    logic [8:0]         w_a20;
    logic [COORD_W-1:0] w_yabs, w_ymir, w_xabs, w_xmir, w_spiral, w_cart, w_f;
    logic [2:0]         w_sel;
    logic [RAD_W-1:0]   w_rad_prod;
    logic [OFS_W-1:0]   w_ofs6, w_ofsr;

    // strip position offset f*1536/LED_COUNT, index clamped to the last LED
    for (genvar gi = 0; gi < IDX_DEPTH; gi++) begin : g_all_ofs
        localparam int Fc   = (gi < LED_COUNT) ? gi : LED_COUNT - 1;
        localparam int Fi   = LED_COUNT - 1 - Fc;
        localparam int OfsF = (Fc * 1536) / LED_COUNT;
        localparam int OfsI = (Fi * 1536) / LED_COUNT;
        assign w_ofs_fwd[gi] = OFS_W'(OfsF);
        assign w_ofs_inv[gi] = OFS_W'(OfsI);
    end

    assign w_rev  = i_cfg.param[PRM_REVERSE];
    assign w_inv  = i_cfg.param[PRM_INVERT];
    assign w_main = i_branch < BRANCH_MAIN;
    assign w_sel  = i_cfg.param[PRM_SEL_LO +: 3];

    assign w_ph = (i_phase >= PHASE_SPAN) ? i_phase - PHASE_SPAN : i_phase;
    assign w_p  = w_rev ? PHASE_LAST - w_ph : w_ph;

    // odd angular sector of (angle + 20) / 43
    assign w_a20 = 9'(i_angle) + 9'(SECTOR_OFS);
    assign w_odd = (w_a20 >= 9'(SECTOR)     && w_a20 < 9'(2 * SECTOR)) ||
                   (w_a20 >= 9'(3 * SECTOR) && w_a20 < 9'(4 * SECTOR)) ||
                   (w_a20 >= 9'(5 * SECTOR) && w_a20 < 9'(6 * SECTOR));

    assign w_yabs   = (i_pos_y >= MID) ? i_pos_y - MID : MID - i_pos_y;
    assign w_ymir   = (i_pos_y <= MID) ? i_pos_y : ~i_pos_y;
    assign w_xabs   = (i_pos_x >= MID) ? i_pos_x - MID : MID - i_pos_x;
    assign w_xmir   = (i_pos_x <= MID) ? i_pos_x : ~i_pos_x;
    assign w_spiral = i_angle + {1'b0, i_radius[COORD_W-1:1]};

    always_comb begin
        case (w_sel)
            CART_X:     w_cart = i_pos_x;
            CART_SUM:   w_cart = i_pos_x + i_pos_y;
            CART_DIFF:  w_cart = i_pos_x - i_pos_y;
            CART_XYABS: w_cart = i_pos_x + w_yabs;
            CART_XYMIR: w_cart = i_pos_x + w_ymir;
            CART_YXABS: w_cart = i_pos_y + w_xabs;
            CART_YXMIR: w_cart = i_pos_y + w_xmir;
            CART_Y:     w_cart = i_pos_y;
            default:    w_cart = i_pos_y;
        endcase
    end

    // 8-bit coordinate; mirror is the bitwise complement
    always_comb begin
        case (i_cfg.mode)
            MODE_RADIAL: w_f = w_inv ? ~i_radius : i_radius;
            MODE_CLOCK:  w_f = i_angle ^ {COORD_W{(i_cfg.param[PRM_ARM_INV] && w_main) ^ w_inv}};
            MODE_RMIX:   w_f = w_odd ? ~i_radius : i_radius;
            MODE_SPIRAL: w_f = w_inv ? ~w_spiral : w_spiral;
            MODE_TREE:   w_f = w_inv ? ~i_branch : i_branch;
            MODE_CART:   w_f = w_inv ? ~w_cart : w_cart;
            default:     w_f = i_angle;
        endcase
    end

    assign w_ofs6     = OFS_W'(w_f) * OFS_W'(6);
    assign w_rad_prod = RAD_W'(w_f) * RAD_W'(RADIAL_SCALE);
    assign w_ofsr     = w_rad_prod[RAD_W-1:8];

    always_comb begin
        n_item.idx  = i_led_index;
        n_item.base = BASE_W'(w_p);
        n_item.ofs  = w_ofs6;
        n_item.dim  = (i_cfg.mode == MODE_CLOCK) && i_cfg.param[PRM_DIM] && w_main;
        case (i_cfg.mode)
            MODE_ALL:    n_item.ofs = w_inv ? w_ofs_inv[i_led_index] : w_ofs_fwd[i_led_index];
            MODE_RADIAL: n_item.ofs = w_ofsr;
            MODE_RMIX: begin
                n_item.base = {w_p, 1'b0};
                n_item.ofs  = w_ofsr;
            end
            MODE_CART:   n_item.base = BASE_W'(w_ph);
            MODE_MONO:   n_item.ofs  = '0;
            default: ;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/lpgp_mix.sv
// Stages 2-5: palette lookup, HSV blend, divide by 255, clock dim, output register.
module lpgp_mix import lpgp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_pos_item          i_item,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_led_index_out,
    output logic [COORD_W-1:0] o_hue,
    output logic [COORD_W-1:0] o_saturation,
    output logic [COORD_W-1:0] o_value
);

    localparam int SEG_W = POS_W - COORD_W;
    localparam int PRD_W = 2 * COORD_W;

    function automatic logic [2:0] mod6(input logic [SEG_W-1:0] s);
        logic [SEG_W-1:0] t;
        if (s >= SEG_W'(2 * PAL_N)) t = s - SEG_W'(2 * PAL_N);
        else if (s >= SEG_W'(PAL_N)) t = s - SEG_W'(PAL_N);
        else t = s;
        return t[2:0];
    endfunction

    // floor(x / 255), exact for 16-bit x
    function automatic logic [COORD_W-1:0] div255(input logic [PRD_W-1:0] x);
        logic [PRD_W:0] t;
        t = (PRD_W+1)'(x) + (PRD_W+1)'(x[PRD_W-1:COORD_W]) + (PRD_W+1)'(1);
        return t[PRD_W-1:COORD_W];
    endfunction

    typedef struct packed {
        logic [COORD_W-1:0] idx;
        logic               dim;
        logic [COORD_W-1:0] pct;
        logic [COORD_W-1:0] h1;
        logic               hneg;
        logic [COORD_W-1:0] hmag;
        logic [COORD_W-1:0] s1;
        logic               sup;
        logic [COORD_W-1:0] smag;
        logic [COORD_W-1:0] v1;
        logic               vup;
        logic [COORD_W-1:0] vmag;
    } t_blend;

    typedef struct packed {
        logic [COORD_W-1:0] idx;
        logic               dim;
        logic [COORD_W-1:0] h1;
        logic               hneg;
        logic [PRD_W-1:0]   hprod;
        logic [COORD_W-1:0] s1;
        logic               sup;
        logic [PRD_W-1:0]   sprod;
        logic [COORD_W-1:0] v1;
        logic               vup;
        logic [PRD_W-1:0]   vprod;
    } t_prod;

    typedef struct packed {
        logic [COORD_W-1:0] idx;
        logic               dim;
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] s;
        logic [COORD_W-1:0] v;
    } t_hsv;

    logic   r2_valid, r3_valid, r4_valid, r5_valid;
    t_blend r2, n2;
    t_prod  r3, n3;
    t_hsv   r4, n4, r5, n5;
    logic   w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    logic [POS_W-1:0]   w_pos;
    logic [2:0]         w_k, w_k2;
    logic [PAL_W-1:0]   w_c1, w_c2;
    logic [COORD_W-1:0] w_h1, w_s1, w_v1, w_h2, w_s2, w_v2;
    logic [COORD_W-1:0] w_h2a, w_h1a, w_h2b, w_h1b, w_dh;
    logic [COORD_W-1:0] w_qh, w_qs, w_qv;
    logic [PRD_W-1:0]   w_s3prod;

    // stall chain: a stage loads when it is empty or its successor loads
    assign w_rdy5  = !r5_valid || i_ready;
    assign w_rdy4  = !r4_valid || w_rdy5;
    assign w_rdy3  = !r3_valid || w_rdy4;
    assign w_rdy2  = !r2_valid || w_rdy3;
    assign o_ready = w_rdy2;

    // stage 2: palette pick and hue fixups
    assign w_pos = POS_W'(i_item.base) + POS_W'(i_item.ofs);
    assign w_k   = mod6(w_pos[POS_W-1:COORD_W]);
    assign w_k2  = (w_k == 3'(PAL_N - 1)) ? 3'd0 : w_k + 3'd1;
    assign w_c1  = i_cfg.palette[w_k];
    assign w_c2  = i_cfg.palette[w_k2];
    assign {w_h1, w_s1, w_v1} = w_c1;
    assign {w_h2, w_s2, w_v2} = w_c2;

    // gray or black endpoints take the other endpoint's hue
    assign w_h2a = (w_v2 == '0) ? w_h1  : w_h2;
    assign w_h1a = (w_v1 == '0) ? w_h2a : w_h1;
    assign w_h2b = (w_s2 == '0) ? w_h1a : w_h2a;
    assign w_h1b = (w_s1 == '0) ? w_h2b : w_h1a;
    assign w_dh  = w_h2b - w_h1b;

    always_comb begin
        n2.idx  = i_item.idx;
        n2.dim  = i_item.dim;
        n2.pct  = w_pos[COORD_W-1:0];
        n2.h1   = w_h1b;
        n2.hneg = w_dh[COORD_W-1];
        n2.hmag = w_dh[COORD_W-1] ? -w_dh : w_dh;
        n2.s1   = w_s1;
        n2.sup  = w_s2 > w_s1;
        n2.smag = (w_s2 > w_s1) ? w_s2 - w_s1 : w_s1 - w_s2;
        n2.v1   = w_v1;
        n2.vup  = w_v2 > w_v1;
        n2.vmag = (w_v2 > w_v1) ? w_v2 - w_v1 : w_v1 - w_v2;
    end

    // stage 3: difference times blend fraction
    always_comb begin
        n3.idx   = r2.idx;
        n3.dim   = r2.dim;
        n3.h1    = r2.h1;
        n3.hneg  = r2.hneg;
        n3.hprod = PRD_W'(r2.hmag) * PRD_W'(r2.pct);
        n3.s1    = r2.s1;
        n3.sup   = r2.sup;
        n3.sprod = PRD_W'(r2.smag) * PRD_W'(r2.pct);
        n3.v1    = r2.v1;
        n3.vup   = r2.vup;
        n3.vprod = PRD_W'(r2.vmag) * PRD_W'(r2.pct);
    end

    // stage 4: truncating /255 and step from the first endpoint
    assign w_qh = div255(r3.hprod);
    assign w_qs = div255(r3.sprod);
    assign w_qv = div255(r3.vprod);

    always_comb begin
        n4.idx = r3.idx;
        n4.dim = r3.dim;
        n4.h   = r3.hneg ? r3.h1 - w_qh : r3.h1 + w_qh;
        n4.s   = r3.sup ? r3.s1 + w_qs : r3.s1 - w_qs;
        n4.v   = r3.vup ? r3.v1 + w_qv : r3.v1 - w_qv;
    end

    // stage 5: clock dim override on the main arm
    assign w_s3prod = PRD_W'(r4.s) * PRD_W'(171);

    always_comb begin
        n5 = r4;
        if (r4.dim) begin
            n5.v = COORD_W'(i_cfg.dim_v);
            case (i_cfg.dim_div)
                DIV_TWO:   n5.s = {1'b0, r4.s[COORD_W-1:1]};
                DIV_THREE: n5.s = COORD_W'(w_s3prod[PRD_W-1:9]);
                DIV_ONE:   n5.s = r4.s;
                default:   n5.s = r4.s;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (w_rdy2) r2_valid <= i_valid;
            if (w_rdy3) r3_valid <= r2_valid;
            if (w_rdy4) r4_valid <= r3_valid;
            if (w_rdy5) r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && i_valid)  r2 <= n2;
        if (w_rdy3 && r2_valid) r3 <= n3;
        if (w_rdy4 && r3_valid) r4 <= n4;
        if (w_rdy5 && r4_valid) r5 <= n5;
    end

    assign o_valid         = r5_valid;
    assign o_led_index_out = r5.idx;
    assign o_hue           = r5.h;
    assign o_saturation    = r5.s;
    assign o_value         = r5.v;

endmodule

>>> rtl/core/led_palette_gradient_pixel.sv
// Top level of the per-LED palette gradient color engine.
// Throughput: one pixel per cycle while the output is ready; the five
// pipeline register stages each take a pixel.
// Backpressure: ready is a per-stage chain, so empty stages keep filling during a stall.
// Reset (synchronous, active low): empties the pipeline, restores the default palette,
// mode all, param 0; clock dim terms follow a param write through the divider registers.
module led_palette_gradient_pixel import lpgp_pkg::*; #(
    parameter int LED_COUNT = 150
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // pixel input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_led_index,
    input  logic [COORD_W-1:0] i_radius,
    input  logic [COORD_W-1:0] i_angle,
    input  logic [COORD_W-1:0] i_branch,
    input  logic [COORD_W-1:0] i_pos_x,
    input  logic [COORD_W-1:0] i_pos_y,
    input  logic [PHASE_W-1:0] i_phase,
    // color output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COORD_W-1:0] o_led_index_out,
    output logic [COORD_W-1:0] o_hue,
    output logic [COORD_W-1:0] o_saturation,
    output logic [COORD_W-1:0] o_value,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_cfg      w_cfg;
    t_pos_item w_pos_item;
    logic      w_pos_valid;
    logic      w_mix_ready;

    // Register file: palette, mode and param, plus the derived dim terms
    // (param/7 % 5 for value, param/11 % 3 picks the saturation divisor).
    lpgp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Stage 1: fold the phase into one palette cycle, apply reverse except in cart
    // mode, pick the mode's coordinate and mirror, turn it into a position offset.
    lpgp_pos #(
        .LED_COUNT (LED_COUNT)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_led_index (i_led_index),
        .i_radius    (i_radius),
        .i_angle     (i_angle),
        .i_branch    (i_branch),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_phase     (i_phase),
        .i_cfg       (w_cfg),
        .o_valid     (w_pos_valid),
        .i_ready     (w_mix_ready),
        .o_item      (w_pos_item)
    );

    // Stages 2-5: palette entry pair and hue fixups, products with the blend
    // fraction, the /255 step, then the clock dim override into the output register.
    lpgp_mix u_mix (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_pos_valid),
        .o_ready         (w_mix_ready),
        .i_item          (w_pos_item),
        .i_cfg           (w_cfg),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_led_index_out (o_led_index_out),
        .o_hue           (o_hue),
        .o_saturation    (o_saturation),
        .o_value         (o_value)
    );

    // Input may only back up when every stage is full and the output is stalled.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while output stage could drain");

    // Mode write lands in the register used by the pipeline.
    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_MODE)
        |=> (w_cfg.mode == t_mode'($past(pwdata[MODE_W-1:0]))))
        else $error("mode register does not hold written value");

    // Param write lands in the register used by the pipeline.
    a_param_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_PARAM)
        |=> (w_cfg.param == $past(pwdata[PARAM_W-1:0])))
        else $error("param register does not hold written value");

endmodule

>>> test/lpgp_colour_checker.sv
// Checker for the palette gradient pixel engine: predicts each pixel color and compares it.
module lpgp_colour_checker import lpgp_pkg::*; #(
    parameter int LED_COUNT = 150
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [COORD_W-1:0] i_led_index,
    input  logic [COORD_W-1:0] i_radius,
    input  logic [COORD_W-1:0] i_angle,
    input  logic [COORD_W-1:0] i_branch,
    input  logic [COORD_W-1:0] i_pos_x,
    input  logic [COORD_W-1:0] i_pos_y,
    input  logic [PHASE_W-1:0] i_phase,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [COORD_W-1:0] i_led_index_out,
    input  logic [COORD_W-1:0] i_hue,
    input  logic [COORD_W-1:0] i_saturation,
    input  logic [COORD_W-1:0] i_value,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [ADDR_W-1:0]  i_paddr,
    input  logic [DATA_W-1:0]  i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // cartesian variant selector
    typedef enum logic [2:0] {
        CART_Y,
        CART_X,
        CART_SUM,
        CART_DIFF,
        CART_X_FOLD_Y,
        CART_X_TENT_Y,
        CART_Y_FOLD_X,
        CART_Y_TENT_X
    } t_cart_sel;

    typedef struct packed {
        logic [COORD_W-1:0] led_index;
        logic [COORD_W-1:0] hue;
        logic [COORD_W-1:0] sat;
        logic [COORD_W-1:0] val;
    } t_colour;

    logic [PAL_W-1:0]   cfg_palette [PAL_N];
    t_mode              cfg_mode;
    logic [PARAM_W-1:0] cfg_param;

    t_colour expected_colours [$];
    int      mismatch_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // monotonic blend, truncating toward the start level
    function automatic int mix_level(input int a, input int b, input int pct);
        if (b > a) return a + ((b - a) * pct) / 255;
        return a - ((a - b) * pct) / 255;
    endfunction

    function automatic t_colour predict_colour(
        input logic [COORD_W-1:0] idx, rad, ang, br, px, py,
        input logic [PHASE_W-1:0] ph_in
    );
        int      ph, p, f, pos, x, y, k, pct, d;
        int      h1, s1, v1, h2, s2, v2, hue, sat, val;
        logic    inv, main_arm;
        t_colour res;
        ph = int'(ph_in);
        if (ph >= 1536) ph -= 1536;
        p = cfg_param[PRM_REVERSE] ? 1535 - ph : ph;
        inv = cfg_param[PRM_INVERT];
        main_arm = (br < 30);
        x = int'(px);
        y = int'(py);
        case (cfg_mode)
            MODE_ALL: begin
                f = (idx >= LED_COUNT) ? LED_COUNT - 1 : int'(idx);
                if (inv) f = LED_COUNT - 1 - f;
                pos = p + f * 1536 / LED_COUNT;
            end
            MODE_RADIAL: begin
                f = inv ? 255 - int'(rad) : int'(rad);
                pos = p + f * 1380 / 256;
            end
            MODE_CLOCK: begin
                f = int'(ang);
                if (cfg_param[PRM_ARM_INV] && main_arm) f = 255 - f;
                if (inv) f = 255 - f;
                pos = p + f * 6;
            end
            MODE_RMIX: begin
                f = int'(rad);
                // odd angular sector mirrors the radius
                if (((int'(ang) + 20) / 43) % 2 == 1) f = 255 - f;
                pos = 2 * p + f * 1380 / 256;
            end
            MODE_SPIRAL: begin
                f = (int'(ang) + int'(rad) / 2) % 256;
                if (inv) f = 255 - f;
                pos = p + f * 6;
            end
            MODE_TREE: begin
                f = inv ? 255 - int'(br) : int'(br);
                pos = p + f * 6;
            end
            MODE_CART: begin
                case (t_cart_sel'(cfg_param[PRM_SEL_LO +: 3]))
                    CART_X:        f = x;
                    CART_SUM:      f = (x + y) % 256;
                    CART_DIFF:     f = (x + 256 - y) % 256;
                    CART_X_FOLD_Y: f = (x + (y >= 128 ? y - 128 : 128 - y)) % 256;
                    CART_X_TENT_Y: f = (x + (y <= 128 ? y : 255 - y)) % 256;
                    CART_Y_FOLD_X: f = (y + (x >= 128 ? x - 128 : 128 - x)) % 256;
                    CART_Y_TENT_X: f = (y + (x <= 128 ? x : 255 - x)) % 256;
                    default:       f = y;
                endcase
                if (inv) f = 255 - f;
                pos = ph + f * 6;  // no reversal here
            end
            default: pos = p;
        endcase

        k   = (pos / 256) % 6;
        pct = pos % 256;
        h1 = int'(cfg_palette[k][23:16]);
        s1 = int'(cfg_palette[k][15:8]);
        v1 = int'(cfg_palette[k][7:0]);
        h2 = int'(cfg_palette[(k + 1) % 6][23:16]);
        s2 = int'(cfg_palette[(k + 1) % 6][15:8]);
        v2 = int'(cfg_palette[(k + 1) % 6][7:0]);
        // a gray or black end takes the other end's hue
        if (v2 == 0) h2 = h1;
        if (v1 == 0) h1 = h2;
        if (s2 == 0) h2 = h1;
        if (s1 == 0) h1 = h2;
        d = (h2 - h1) & 255;
        if (d >= 128) d -= 256;
        hue = (h1 + (d * pct) / 255) & 255;
        sat = mix_level(s1, s2, pct);
        val = mix_level(v1, v2, pct);

        if (cfg_mode == MODE_CLOCK && cfg_param[PRM_DIM] && main_arm) begin
            val = (int'(cfg_param) / 7) % 5;
            sat = sat / ((int'(cfg_param) / 11) % 3 + 1);
        end

        res.led_index = idx;
        res.hue = hue[7:0];
        res.sat = sat[7:0];
        res.val = val[7:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_colour want;
        if (!i_rst_n) begin
            cfg_palette[0] = 24'h00FFFF;
            cfg_palette[1] = 24'h2BFFFF;
            cfg_palette[2] = 24'h55FFFF;
            cfg_palette[3] = 24'h80FFFF;
            cfg_palette[4] = 24'hABFFFF;
            cfg_palette[5] = 24'hD5FFFF;
            cfg_mode  = MODE_ALL;
            cfg_param = '0;
            expected_colours.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_colours.size() == 0) begin
                    $error("unexpected color transaction: led_index_out %0d", i_led_index_out);
                    mismatch_count++;
                end else begin
                    want = expected_colours.pop_front();
                    check_field("led_index_out", want.led_index, i_led_index_out);
                    check_field("hue", want.hue, i_hue);
                    check_field("saturation", want.sat, i_saturation);
                    check_field("value", want.val, i_value);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_colours.push_back(predict_colour(i_led_index, i_radius, i_angle,
                                                          i_branch, i_pos_x, i_pos_y, i_phase));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[4:2]))
                    REG_MODE:  cfg_mode = t_mode'(i_pwdata[MODE_W-1:0]);
                    REG_PARAM: cfg_param = i_pwdata[PARAM_W-1:0];
                    default:   cfg_palette[i_paddr[4:2]] = i_pwdata[PAL_W-1:0];
                endcase
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_colours.size();
    end

endmodule

>>> test/tb_top.sv
// Testbench top for the palette gradient pixel engine: stimulus, handshakes and verdict.
module tb_top;
    import lpgp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEDS        = 150;
    localparam int PHASES      = 16;   // random configuration phases
    localparam int PER_PHASE   = 125;  // pixels per random phase
    localparam int HOLD_CYCLES = 80;   // long output stall
    localparam int IDLE_PCT    = 23;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [COORD_W-1:0] i_led_index;
    logic [COORD_W-1:0] i_radius;
    logic [COORD_W-1:0] i_angle;
    logic [COORD_W-1:0] i_branch;
    logic [COORD_W-1:0] i_pos_x;
    logic [COORD_W-1:0] i_pos_y;
    logic [PHASE_W-1:0] i_phase;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [COORD_W-1:0] o_led_index_out;
    logic [COORD_W-1:0] o_hue;
    logic [COORD_W-1:0] o_saturation;
    logic [COORD_W-1:0] o_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int fail_count;
    int pending;

    // quiet_mode: neither side idles; hold_request: receiver does one long stall
    bit quiet_mode   = 1'b0;
    bit hold_request = 1'b0;

    // settings for the next configuration phase
    logic [PAL_W-1:0]   next_palette [PAL_N];
    t_mode              next_mode;
    logic [PARAM_W-1:0] next_param;

    // params for the directed pass, one per mode: reset value for mode all, then
    // invert, every clock bit, reverse, invert, none, cartesian variant 7 inverted, reverse
    logic [PARAM_W-1:0] directed_param [8] = '{16'h0000, 16'h0002, 16'h000F, 16'h0001,
                                               16'h0002, 16'h0000, 16'h001E, 16'h0001};

    led_palette_gradient_pixel #(
        .LED_COUNT(LEDS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_led_index     (i_led_index),
        .i_radius        (i_radius),
        .i_angle         (i_angle),
        .i_branch        (i_branch),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_phase         (i_phase),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_led_index_out (o_led_index_out),
        .o_hue           (o_hue),
        .o_saturation    (o_saturation),
        .o_value         (o_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    lpgp_colour_checker #(
        .LED_COUNT(LEDS)
    ) u_colour_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_led_index     (i_led_index),
        .i_radius        (i_radius),
        .i_angle         (i_angle),
        .i_branch        (i_branch),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_phase         (i_phase),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_led_index_out (o_led_index_out),
        .i_hue           (o_hue),
        .i_saturation    (o_saturation),
        .i_value         (o_value),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous run limit; a correct run finishes well before it.
    initial begin
        #2ms;
        $display("led_palette_gradient_pixel test failed");
        $finish;
    end

    // Color receiver. Ready is redrawn every cycle; on request it drops for a
    // long stretch so the pipeline fills behind it and o_in_ready falls.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one pixel transaction. Valid stays high from the previous pixel
    // unless an idle gap is drawn; returns right after the accepting edge.
    task automatic send_pixel(input logic [7:0] idx, rad, ang, br, px, py,
                              input logic [10:0] ph);
        while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_led_index <= idx;
        i_radius    <= rad;
        i_angle     <= ang;
        i_branch    <= br;
        i_pos_x     <= px;
        i_pos_y     <= py;
        i_phase     <= ph;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Random pixel: mostly in-range index and phase, some beyond, branch often on
    // the main arm so the clock-mode arm bits matter.
    task automatic send_random_pixel();
        logic [7:0]  idx, br;
        logic [10:0] ph;
        idx = ($urandom_range(9) == 0) ? 8'($urandom_range(255, LEDS)) : 8'($urandom_range(LEDS - 1));
        br  = $urandom_range(1) ? 8'($urandom_range(29)) : 8'($urandom);
        ph  = ($urandom_range(7) == 0) ? 11'($urandom_range(2047, 1536)) : 11'($urandom_range(1535));
        send_pixel(idx, 8'($urandom), 8'($urandom), br, 8'($urandom), 8'($urandom), ph);
    endtask

    // Stop offering and wait until every expected color has come back, then
    // let the pipeline latency (5 stages) run out before touching registers.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Setup then access cycle; the register is written when access ends.
    // psel stays up so back-to-back writes need no idle gap.
    task automatic write_reg(input t_reg_idx which, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    // Close a write burst. The clock dim terms trail a param write through the
    // divider registers, so pixels hold off a little longer.
    task automatic end_writes();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings();
        for (int e = 0; e < PAL_N; e++)
            write_reg(t_reg_idx'(e), DATA_W'(next_palette[e]));
        write_reg(REG_MODE, DATA_W'(next_mode));
        write_reg(REG_PARAM, DATA_W'(next_param));
        end_writes();
    endtask

    // Palette color with a bias toward the hue replacement corners: gray,
    // black, all zero and all ones.
    function automatic logic [PAL_W-1:0] random_swatch();
        logic [7:0] h, s, v;
        h = 8'($urandom);
        s = 8'($urandom);
        v = 8'($urandom);
        case ($urandom_range(7))
            0:       return {h, 8'h00, v};
            1:       return {h, s, 8'h00};
            2:       return '0;
            3:       return '1;
            default: return {h, s, v};
        endcase
    endfunction

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_led_index <= '0;
        i_radius    <= '0;
        i_angle     <= '0;
        i_branch    <= '0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_phase     <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass: every mode, with the reset palette. Mode all runs on the
        // reset register values. Per mode: all zero, the top of every field with
        // the last valid index and phase, and a pixel with both beyond range,
        // sitting on the main-arm and radial-mix sector edges.
        for (int m = 0; m < 8; m++) begin
            if (m != 0) begin
                drain();
                write_reg(REG_MODE, DATA_W'(m));
                write_reg(REG_PARAM, DATA_W'(directed_param[m]));
                end_writes();
            end
            send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 11'd0);
            send_pixel(8'd149, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 11'd1535);
            send_pixel(8'd150, 8'd128, 8'd23, 8'd29, 8'd128, 8'd128, 11'd1536);
        end
        // widest index and phase in mode all
        drain();
        write_reg(REG_MODE, DATA_W'(MODE_ALL));
        end_writes();
        send_pixel(8'd255, 8'd1, 8'd22, 8'd30, 8'd127, 8'd129, 11'd2047);

        // Random phases: each mode twice, fresh palette and param each time.
        // The first two are the extremes; the third carries the long output
        // stall; the fifth runs with no idling on either side.
        for (int n = 0; n < PHASES; n++) begin
            drain();
            next_mode = t_mode'(n[2:0]);
            for (int e = 0; e < PAL_N; e++) begin
                if (n == 0)      next_palette[e] = '0;
                else if (n == 1) next_palette[e] = '1;
                else             next_palette[e] = random_swatch();
            end
            if (n == 0)                         next_param = '0;
            else if (n == 1)                    next_param = '1;
            else if ($urandom_range(7) == 0)    next_param = '1;
            else                                next_param = PARAM_W'($urandom);
            load_settings();

            quiet_mode = (n == 4);
            if (n == 2) hold_request = 1'b1;
            for (int i = 0; i < PER_PHASE; i++)
                send_random_pixel();
        end
        quiet_mode = 1'b0;

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("led_palette_gradient_pixel test passed");
        end else begin
            $display("led_palette_gradient_pixel test failed");
        end
        $finish;
    end

endmodule

>>> led_palette_gradient_pixel.f
rtl/core/lpgp_pkg.sv
rtl/core/lpgp_regs.sv
rtl/core/lpgp_pos.sv
rtl/core/lpgp_mix.sv
rtl/core/led_palette_gradient_pixel.sv
test/lpgp_colour_checker.sv
test/tb_top.sv
